// ===== rtl/glkc_pkg.sv =====
// Package for the glyph key cache directory: field widths, status codes
// and defaults shared by the interfaces, the RAM user and the top level.
// Depends on nothing.
package glkc_pkg;

  localparam int CP_W     = 21;
  localparam int SIZE_W   = 10;
  localparam int CFG_W    = 9;
  localparam int STAMP_W  = 64;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;

  localparam int ENTRIES_DEF = 256;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef logic [CP_W-1:0]     codepoint_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [STAMP_W-1:0]  stamp_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CFG_W-1:0]    cfg_t;

endpackage

// ===== rtl/glkc_req_if.sv =====
// Request and result channel interfaces of the glyph key cache directory.
// Each carries valid, ready and the payload fields; depends on glkc_pkg.
interface glkc_req_if;
  import glkc_pkg::*;

  logic       valid;
  logic       ready;
  codepoint_t codepoint;
  size_t      pixel_size;

  modport source (output valid, output codepoint, output pixel_size, input ready);
  modport sink   (input valid, input codepoint, input pixel_size, output ready);
endinterface

interface glkc_rsp_if;
  import glkc_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  slot_t   slot_index;
  logic    evicted;
  count_t  hit_total;
  count_t  miss_total;

  modport source (output valid, output status, output slot_index, output evicted,
                  output hit_total, output miss_total, input ready);
  modport sink   (input valid, input status, input slot_index, input evicted,
                  input hit_total, input miss_total, output ready);
endinterface

// ===== rtl/glyph_key_lru_cache_directory_core.sv =====
// Top level of the glyph key cache directory: request sequencer, entry RAM,
// fill count, use tick and hit and miss counters.
// Depends on glkc_pkg, glkc_req_if, glkc_rsp_if and glkc_ram.
//
// Usage: requests (codepoint, pixel size) arrive on in_ch and one result per
// request leaves on out_ch; both are valid/ready channels and a transfer
// happens on a rising edge with valid and ready high. cfg_we with cfg_wdata
// sets the number of entries in use; the user must see that it is written
// only while idle, as the block itself does not enforce this. A request is
// taken only while the sequencer is idle; a zero pixel size skips the
// search. Otherwise it reads the filled entries among those in use from the
// entry RAM, one per cycle, with the compare in the cycle after the read,
// and stops at the first match; a miss searches every filled entry in use.
// It ends in a write-back state that holds until the output register is
// free; a zero pixel size writes nothing back. Filled entries always form a
// prefix, so a fill count replaces per-entry valid bits and no clearing pass
// follows reset.
// Reset empties the directory, clears the tick and counters and sets the
// entries in use to min(256, ENTRIES). The result sits in an output
// register; a new request can be taken and searched while it waits, and
// its write-back holds until the receiver takes the earlier result.
module glyph_key_lru_cache_directory_core #(
  parameter int ENTRIES = glkc_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  glkc_req_if.sink          in_ch,
  glkc_rsp_if.source        out_ch,
  input  logic              cfg_we,
  input  glkc_pkg::cfg_t    cfg_wdata
);
  import glkc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int NW = $clog2(ENTRIES + 1);
  localparam int DW = CP_W + SIZE_W + STAMP_W;
  localparam logic [NW-1:0] ENT_N = NW'(ENTRIES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  cfg_t          cfg_r;
  logic [NW-1:0] fill_r, fill_nxt;
  stamp_t        tick_r, tick_nxt;
  count_t        hit_r, hit_nxt;
  count_t        miss_r, miss_nxt;

  codepoint_t    cp_r, cp_nxt;
  size_t         sz_r, sz_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] m_r, m_nxt;
  logic [NW-1:0] iss_r, iss_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  stamp_t        min_r, min_nxt;
  logic [AW-1:0] lru_r, lru_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  status_t       stat_r, stat_nxt;
  logic          ev_r, ev_nxt;
  logic          grow_r, grow_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  slot_t         out_slot_r, out_slot_nxt;
  logic          out_ev_r, out_ev_nxt;
  count_t        out_hit_r, out_hit_nxt;
  count_t        out_miss_r, out_miss_nxt;

  logic          rd_en;
  logic [DW-1:0] rdata;
  logic          ram_we;
  logic [DW-1:0] wdata;
  codepoint_t    rd_cp;
  size_t         rd_sz;
  stamp_t        rd_stamp;
  logic          out_free;
  logic [NW-1:0] n_calc;
  logic [31:0]   slot_wide;
  stamp_t        tick_inc;

  assign rd_cp    = rdata[DW-1 -: CP_W];
  assign rd_sz    = rdata[STAMP_W +: SIZE_W];
  assign rd_stamp = rdata[STAMP_W-1:0];
  assign tick_inc = tick_r + 64'd1;
  assign wdata    = {cp_r, sz_r, tick_inc};
  assign out_free = !out_valid_r || out_ch.ready;
  assign rd_en    = (state_r == S_SCAN) && (iss_r < m_r);
  assign ram_we   = (state_r == S_WRITE) && out_free && (stat_r != ST_INVALID);
  assign slot_wide = 32'(slot_r);

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_index = out_slot_r;
  assign out_ch.evicted    = out_ev_r;
  assign out_ch.hit_total  = out_hit_r;
  assign out_ch.miss_total = out_miss_r;

  always_comb begin
    if (cfg_r == '0) begin
      n_calc = NW'(1);
    end else if (32'(cfg_r) > 32'(ENTRIES)) begin
      n_calc = ENT_N;
    end else begin
      n_calc = NW'(cfg_r);
    end
  end

  glkc_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (iss_r[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    tick_nxt       = tick_r;
    hit_nxt        = hit_r;
    miss_nxt       = miss_r;
    cp_nxt         = cp_r;
    sz_nxt         = sz_r;
    n_nxt          = n_r;
    m_nxt          = m_r;
    iss_nxt        = iss_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = iss_r[AW-1:0];
    min_nxt        = min_r;
    lru_nxt        = lru_r;
    slot_nxt       = slot_r;
    stat_nxt       = stat_r;
    ev_nxt         = ev_r;
    grow_nxt       = grow_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_ev_nxt     = out_ev_r;
    out_hit_nxt    = out_hit_r;
    out_miss_nxt   = out_miss_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cp_nxt   = in_ch.codepoint;
          sz_nxt   = in_ch.pixel_size;
          n_nxt    = n_calc;
          m_nxt    = (fill_r < n_calc) ? fill_r : n_calc;
          iss_nxt  = '0;
          slot_nxt = '0;
          ev_nxt   = 1'b0;
          grow_nxt = 1'b0;
          if (in_ch.pixel_size == '0) begin
            stat_nxt  = ST_INVALID;
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          iss_nxt     = iss_r + NW'(1);
          cmp_vld_nxt = 1'b1;
        end
        if (cmp_vld_r) begin
          if (rd_cp == cp_r && rd_sz == sz_r) begin
            stat_nxt    = ST_HIT;
            slot_nxt    = cmp_idx_r;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_WRITE;
          end else if (cmp_idx_r == '0 || rd_stamp < min_r) begin
            min_nxt = rd_stamp;
            lru_nxt = cmp_idx_r;
          end
        end else if (!rd_en) begin
          stat_nxt  = ST_MISS;
          state_nxt = S_WRITE;
          if (fill_r < n_r) begin
            slot_nxt = fill_r[AW-1:0];
            grow_nxt = 1'b1;
          end else begin
            slot_nxt = lru_r;
            ev_nxt   = 1'b1;
          end
        end
      end
      S_WRITE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_slot_nxt   = slot_wide[SLOT_W-1:0];
          out_ev_nxt     = ev_r;
          out_hit_nxt    = hit_r;
          out_miss_nxt   = miss_r;
          if (stat_r == ST_HIT) begin
            tick_nxt    = tick_inc;
            hit_nxt     = hit_r + 32'd1;
            out_hit_nxt = hit_r + 32'd1;
          end else if (stat_r == ST_MISS) begin
            tick_nxt     = tick_inc;
            miss_nxt     = miss_r + 32'd1;
            out_miss_nxt = miss_r + 32'd1;
            if (grow_r) begin
              fill_nxt = fill_r + NW'(1);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_RESET;
      fill_r      <= '0;
      tick_r      <= '0;
      hit_r       <= '0;
      miss_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      tick_r      <= tick_nxt;
      hit_r       <= hit_nxt;
      miss_r      <= miss_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r         <= cp_nxt;
    sz_r         <= sz_nxt;
    n_r          <= n_nxt;
    m_r          <= m_nxt;
    iss_r        <= iss_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    min_r        <= min_nxt;
    lru_r        <= lru_nxt;
    slot_r       <= slot_nxt;
    stat_r       <= stat_nxt;
    ev_r         <= ev_nxt;
    grow_r       <= grow_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ev_r     <= out_ev_nxt;
    out_hit_r    <= out_hit_nxt;
    out_miss_r   <= out_miss_nxt;
  end

endmodule

// ===== rtl/glkc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; depends on nothing.
module glkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
